/* rtl/slr_pkg.sv */
`default_nettype none
package slr_pkg;

    localparam int NUM_VARS = 3;

    localparam logic signed [63:0] SAT_HI     = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO     = -64'sd2147483648;
    localparam logic signed [63:0] SAT_SYM_LO = -64'sd2147483647;

    typedef enum logic [2:0] {
        OP_DL  = 3'd0,
        OP_DR  = 3'd1,
        OP_R   = 3'd2,
        OP_LIM = 3'd3,
        OP_C   = 3'd4
    } t_op;

    typedef logic [1:0] t_vsel;

    typedef struct packed {
        logic  load;
        logic  dx;
        logic  div_start;
        logic  div_write;
        logic  mula;
        logic  mulb;
        logic  mull;
        logic  slope;
        logic  out_int;
        logic  out_const;
        logic  commit;
        t_op   op;
        t_vsel vsel;
    } t_cmd;

    typedef struct packed {
        logic [1:0] fill;
        logic       pend;
        logic       last;
        logic       mom_nz;
        logic       r_big;
        logic       div_done;
        logic       out_free;
    } t_sts;

    function automatic logic signed [31:0] sat_sym(input logic signed [63:0] q);
        logic signed [31:0] res;
        if (q > SAT_HI) begin
            res = 32'sh7fffffff;
        end else if (q < SAT_SYM_LO) begin
            res = -32'sh7fffffff;
        end else begin
            res = q[31:0];
        end
        return res;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] q);
        logic signed [31:0] res;
        if (q > SAT_HI) begin
            res = 32'sh7fffffff;
        end else if (q < SAT_LO) begin
            res = 32'sh80000000;
        end else begin
            res = q[31:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

/* rtl/slope_limited_linear_reconstruction.sv */
// Slope-limited linear reconstruction, one finite-volume cell per input transfer.
// Input channel i_valid/o_stall carries a cell in row order; output channel
// o_valid/i_stall carries results (cell number, updated, mean and slope per
// variable, row done). A cell gives zero, one or two results.
// One cell at a time: o_stall is high from the transfer until the cell is done.
// Cells that need no arithmetic pass only through the plan, output and commit
// states. An interior cell to be reconstructed runs nine to eleven quotients
// through one shared divider that resolves one bit per cycle (a zero divisor
// skips the bit loop and gives zero), plus multiply and control states;
// the divider sets the throughput.
// The interior result for a cell appears after the next cell is transferred.
// Results sit in an output register; while o_valid and i_stall are both high
// the register holds and the block waits before writing another result.
// Reset (i_rst_n low, synchronous) empties the window, clears the cell index
// and drops o_valid.
`default_nettype none
module slope_limited_linear_reconstruction #(
    parameter int FRACTION_BITS = 16,
    parameter int INDEX_BITS    = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_left_node,
    input  wire logic signed [31:0] i_right_node,
    input  wire logic signed [31:0] i_density_value,
    input  wire logic signed [31:0] i_momentum_value,
    input  wire logic signed [31:0] i_energy_value,
    input  wire logic               i_reconstruct_flag,
    input  wire logic               i_final_cell,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [15:0]             o_cell_number,
    output logic                    o_updated,
    output logic signed [31:0]      o_density_mean,
    output logic signed [31:0]      o_density_slope,
    output logic signed [31:0]      o_momentum_mean,
    output logic signed [31:0]      o_momentum_slope,
    output logic signed [31:0]      o_energy_mean,
    output logic signed [31:0]      o_energy_slope,
    output logic                    o_row_done
);
    import slr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    slr_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_sts  (sts),
        .o_cmd  (cmd)
    );

    slr_dpath #(
        .FRACTION_BITS(FRACTION_BITS),
        .INDEX_BITS   (INDEX_BITS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_left_node       (i_left_node),
        .i_right_node      (i_right_node),
        .i_density_value   (i_density_value),
        .i_momentum_value  (i_momentum_value),
        .i_energy_value    (i_energy_value),
        .i_reconstruct_flag(i_reconstruct_flag),
        .i_final_cell      (i_final_cell),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_cell_number     (o_cell_number),
        .o_updated         (o_updated),
        .o_density_mean    (o_density_mean),
        .o_density_slope   (o_density_slope),
        .o_momentum_mean   (o_momentum_mean),
        .o_momentum_slope  (o_momentum_slope),
        .o_energy_mean     (o_energy_mean),
        .o_energy_slope    (o_energy_slope),
        .o_row_done        (o_row_done)
    );

endmodule
`default_nettype wire

/* rtl/slr_div.sv */
`default_nettype none
module slr_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [63:0] i_num,
    input  wire logic signed [63:0] i_den,
    output logic                    o_done,
    output logic signed [63:0]      o_quo
);
    import slr_pkg::*;

    logic        r_busy, r_done, r_neg;
    logic [5:0]  r_cnt;
    logic [63:0] r_rem, r_q, r_den;
    logic signed [63:0] r_res;

    logic [64:0] rem_sh, trial;
    logic [63:0] n_rem, n_q;

    always_comb begin
        rem_sh = {r_rem, r_q[63]};
        trial  = rem_sh - {1'b0, r_den};
        if (!trial[64]) begin
            n_rem = trial[63:0];
            n_q   = {r_q[62:0], 1'b1};
        end else begin
            n_rem = rem_sh[63:0];
            n_q   = {r_q[62:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= (i_den != 64'sd0);
                r_done <= (i_den == 64'sd0);
            end else if (r_busy && r_cnt == 6'd63) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num[63] ? 64'(-i_num) : 64'(i_num);
            r_den <= i_den[63] ? 64'(-i_den) : 64'(i_den);
            r_rem <= '0;
            r_cnt <= '0;
            r_neg <= i_num[63] ^ i_den[63];
            r_res <= '0;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                r_res <= r_neg ? -$signed(n_q) : $signed(n_q);
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_res;

endmodule
`default_nettype wire

/* rtl/slr_dpath.sv */
`default_nettype none
module slr_dpath #(
    parameter int FRACTION_BITS = 16,
    parameter int INDEX_BITS    = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire slr_pkg::t_cmd      i_cmd,
    output slr_pkg::t_sts           o_sts,
    input  wire logic signed [31:0] i_left_node,
    input  wire logic signed [31:0] i_right_node,
    input  wire logic signed [31:0] i_density_value,
    input  wire logic signed [31:0] i_momentum_value,
    input  wire logic signed [31:0] i_energy_value,
    input  wire logic               i_reconstruct_flag,
    input  wire logic               i_final_cell,
    input  wire logic               i_stall,
    output logic                    o_valid,
    output logic [15:0]             o_cell_number,
    output logic                    o_updated,
    output logic signed [31:0]      o_density_mean,
    output logic signed [31:0]      o_density_slope,
    output logic signed [31:0]      o_momentum_mean,
    output logic signed [31:0]      o_momentum_slope,
    output logic signed [31:0]      o_energy_mean,
    output logic signed [31:0]      o_energy_slope,
    output logic                    o_row_done
);
    import slr_pkg::*;

    localparam logic signed [63:0] ONE     = 64'sd1 <<< FRACTION_BITS;
    localparam logic signed [63:0] LIM_NUM = 64'sd1 <<< (2 * FRACTION_BITS + 1);

    logic signed [31:0] r_prev [NUM_VARS];
    logic signed [31:0] r_mid  [NUM_VARS];
    logic signed [31:0] r_cur  [NUM_VARS];
    logic signed [31:0] r_dl   [NUM_VARS];
    logic signed [31:0] r_dr   [NUM_VARS];
    logic signed [31:0] r_slope[NUM_VARS];
    logic signed [31:0] r_left, r_right, r_wl0, r_wl1, r_dxl, r_dxr, r_lim, r_c;
    logic signed [63:0] r_pa, r_pb;
    logic               r_flag, r_last, r_pend;
    logic [1:0]         r_fill;
    logic [INDEX_BITS-1:0] r_idx;

    logic               r_ovalid, r_oupd, r_odone;
    logic [15:0]        r_ocell;
    logic signed [31:0] r_omean [NUM_VARS];
    logic signed [31:0] r_oslope[NUM_VARS];

    logic signed [32:0] diff_l, diff_r, d_left, d_right;
    logic signed [63:0] div_num, div_den, div_q, mul_a, mul_b, prod, p_adj;
    logic signed [31:0] mul_a32, mul_b32;
    logic               div_done, taken, out_free;
    logic [INDEX_BITS-1:0] idx_prev;
    t_vsel vs;

    assign vs       = i_cmd.vsel;
    assign diff_l   = {r_left[31], r_left} - {r_wl0[31], r_wl0};
    assign diff_r   = {r_right[31], r_right} - {r_wl1[31], r_wl1};
    assign d_left   = {r_mid[vs][31], r_mid[vs]} - {r_prev[vs][31], r_prev[vs]};
    assign d_right  = {r_cur[vs][31], r_cur[vs]} - {r_mid[vs][31], r_mid[vs]};
    assign idx_prev = r_idx - INDEX_BITS'(1);

    always_comb begin
        case (i_cmd.op)
            OP_DL: begin
                div_num = {{31{d_left[32]}}, d_left} <<< FRACTION_BITS;
                div_den = {{32{r_dxl[31]}}, r_dxl};
            end
            OP_DR: begin
                div_num = {{31{d_right[32]}}, d_right} <<< FRACTION_BITS;
                div_den = {{32{r_dxr[31]}}, r_dxr};
            end
            OP_R: begin
                div_num = {{32{r_dl[1][31]}}, r_dl[1]} <<< FRACTION_BITS;
                div_den = {{32{r_dr[1][31]}}, r_dr[1]};
            end
            OP_LIM: begin
                div_num = LIM_NUM;
                div_den = ONE + div_q;
            end
            OP_C: begin
                div_num = r_pa + r_pb;
                div_den = {{32{r_dxl[31]}}, r_dxl} + {{32{r_dxr[31]}}, r_dxr};
            end
            default: begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    slr_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_done (div_done),
        .o_quo  (div_q)
    );

    always_comb begin
        if (i_cmd.mula) begin
            mul_a32 = r_dxr;
            mul_b32 = r_dl[vs];
        end else if (i_cmd.mulb) begin
            mul_a32 = r_dxl;
            mul_b32 = r_dr[vs];
        end else begin
            mul_a32 = r_lim;
            mul_b32 = r_c;
        end
        mul_a = {{32{mul_a32[31]}}, mul_a32};
        mul_b = {{32{mul_b32[31]}}, mul_b32};
        prod  = mul_a * mul_b;
        p_adj = r_pa + (r_pa[63] ? (ONE - 64'sd1) : 64'sd0);
    end

    assign taken    = r_ovalid && !i_stall;
    assign out_free = !r_ovalid || !i_stall;

    always_comb begin
        o_sts.fill     = r_fill;
        o_sts.pend     = r_pend;
        o_sts.last     = r_last;
        o_sts.mom_nz   = (r_dl[1] != 32'sd0) && (r_dr[1] != 32'sd0);
        o_sts.r_big    = div_q > ONE;
        o_sts.div_done = div_done;
        o_sts.out_free = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_idx    <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                if (r_last) begin
                    r_fill <= '0;
                    r_idx  <= '0;
                    r_pend <= 1'b0;
                end else begin
                    r_fill <= (r_fill == 2'd2) ? 2'd2 : r_fill + 2'd1;
                    r_idx  <= r_idx + INDEX_BITS'(1);
                    r_pend <= r_flag;
                end
            end
            if (i_cmd.out_int || i_cmd.out_const) begin
                r_ovalid <= 1'b1;
            end else if (taken) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur[0] <= i_density_value;
            r_cur[1] <= i_momentum_value;
            r_cur[2] <= i_energy_value;
            r_left   <= i_left_node;
            r_right  <= i_right_node;
            r_flag   <= i_reconstruct_flag;
            r_last   <= i_final_cell;
            r_lim    <= '0;
        end
        if (i_cmd.dx) begin
            r_dxl <= 32'(diff_l >>> 1);
            r_dxr <= 32'(diff_r >>> 1);
        end
        if (i_cmd.div_write) begin
            case (i_cmd.op)
                OP_DL:  r_dl[vs] <= sat_sym(div_q);
                OP_DR:  r_dr[vs] <= sat_sym(div_q);
                OP_R:   r_lim <= (div_q > 64'sd0 && div_q <= ONE) ? div_q[31:0] : 32'sd0;
                OP_LIM: r_lim <= div_q[31:0];
                OP_C:   r_c <= sat32(div_q);
                default: r_c <= r_c;
            endcase
        end
        if (i_cmd.mula || i_cmd.mull) begin
            r_pa <= prod;
        end
        if (i_cmd.mulb) begin
            r_pb <= prod;
        end
        if (i_cmd.slope) begin
            r_slope[vs] <= sat32(p_adj >>> FRACTION_BITS);
        end
        if (i_cmd.commit && !r_last) begin
            for (int v = 0; v < NUM_VARS; v++) begin
                r_prev[v] <= r_mid[v];
                r_mid[v]  <= r_cur[v];
            end
            r_wl0 <= r_wl1;
            r_wl1 <= r_left;
        end
        if (i_cmd.out_int) begin
            r_ocell <= 16'(idx_prev);
            r_oupd  <= r_pend;
            r_odone <= 1'b0;
            for (int v = 0; v < NUM_VARS; v++) begin
                r_omean[v]  <= r_pend ? r_mid[v] : 32'sd0;
                r_oslope[v] <= r_pend ? r_slope[v] : 32'sd0;
            end
        end else if (i_cmd.out_const) begin
            r_ocell <= 16'(r_idx);
            r_oupd  <= 1'b1;
            r_odone <= r_last;
            for (int v = 0; v < NUM_VARS; v++) begin
                r_omean[v]  <= r_cur[v];
                r_oslope[v] <= 32'sd0;
            end
        end
    end

    assign o_valid          = r_ovalid;
    assign o_cell_number    = r_ocell;
    assign o_updated        = r_oupd;
    assign o_row_done       = r_odone;
    assign o_density_mean   = r_omean[0];
    assign o_density_slope  = r_oslope[0];
    assign o_momentum_mean  = r_omean[1];
    assign o_momentum_slope = r_oslope[1];
    assign o_energy_mean    = r_omean[2];
    assign o_energy_slope   = r_oslope[2];

endmodule
`default_nettype wire

/* rtl/slr_ctrl.sv */
`default_nettype none
module slr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire slr_pkg::t_sts i_sts,
    output slr_pkg::t_cmd      o_cmd
);
    import slr_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b000000000001,
        ST_PLAN   = 12'b000000000010,
        ST_DX     = 12'b000000000100,
        ST_DIV    = 12'b000000001000,
        ST_WAIT   = 12'b000000010000,
        ST_MULA   = 12'b000000100000,
        ST_MULB   = 12'b000001000000,
        ST_MULL   = 12'b000010000000,
        ST_SLOPE  = 12'b000100000000,
        ST_OUTI   = 12'b001000000000,
        ST_OUTC   = 12'b010000000000,
        ST_COMMIT = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    t_vsel  r_vsel, n_vsel;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_vsel  = r_vsel;
        o_cmd   = '0;
        o_cmd.op   = r_op;
        o_cmd.vsel = r_vsel;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_PLAN;
                end
            end
            ST_PLAN: begin
                if (i_sts.fill == 2'd0) begin
                    n_state = ST_OUTC;
                end else if (i_sts.fill == 2'd2) begin
                    n_state = i_sts.pend ? ST_DX : ST_OUTI;
                end else begin
                    n_state = i_sts.last ? ST_OUTC : ST_COMMIT;
                end
            end
            ST_DX: begin
                o_cmd.dx = 1'b1;
                n_op    = OP_DL;
                n_vsel  = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.div_write = 1'b1;
                    case (r_op)
                        OP_DL: begin
                            n_state = ST_DIV;
                            if (r_vsel == 2'd2) begin
                                n_op   = OP_DR;
                                n_vsel = '0;
                            end else begin
                                n_vsel = r_vsel + 2'd1;
                            end
                        end
                        OP_DR: begin
                            if (r_vsel != 2'd2) begin
                                n_vsel  = r_vsel + 2'd1;
                                n_state = ST_DIV;
                            end else if (i_sts.mom_nz) begin
                                n_op    = OP_R;
                                n_state = ST_DIV;
                            end else begin
                                n_vsel  = '0;
                                n_state = ST_MULA;
                            end
                        end
                        OP_R: begin
                            if (i_sts.r_big) begin
                                n_op    = OP_LIM;
                                n_state = ST_DIV;
                            end else begin
                                n_vsel  = '0;
                                n_state = ST_MULA;
                            end
                        end
                        OP_LIM: begin
                            n_vsel  = '0;
                            n_state = ST_MULA;
                        end
                        OP_C: begin
                            n_state = ST_MULL;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_MULA: begin
                o_cmd.mula = 1'b1;
                n_state = ST_MULB;
            end
            ST_MULB: begin
                o_cmd.mulb = 1'b1;
                n_op    = OP_C;
                n_state = ST_DIV;
            end
            ST_MULL: begin
                o_cmd.mull = 1'b1;
                n_state = ST_SLOPE;
            end
            ST_SLOPE: begin
                o_cmd.slope = 1'b1;
                if (r_vsel == 2'd2) begin
                    n_state = ST_OUTI;
                end else begin
                    n_vsel  = r_vsel + 2'd1;
                    n_state = ST_MULA;
                end
            end
            ST_OUTI: begin
                if (i_sts.out_free) begin
                    o_cmd.out_int = 1'b1;
                    n_state = i_sts.last ? ST_OUTC : ST_COMMIT;
                end
            end
            ST_OUTC: begin
                if (i_sts.out_free) begin
                    o_cmd.out_const = 1'b1;
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_DL;
            r_vsel  <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_vsel  <= n_vsel;
        end
    end

    assign o_stall = (r_state != ST_IDLE);

endmodule
`default_nettype wire

/* test/slope_limited_linear_reconstruction_test.sv */
`default_nettype none
module slope_limited_linear_reconstruction_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam int IDX_BITS = 16;
    localparam longint CYCLE_LIMIT = 10000000;

    typedef struct packed {
        logic signed [31:0] left_node;
        logic signed [31:0] right_node;
        logic signed [31:0] density;
        logic signed [31:0] momentum;
        logic signed [31:0] energy;
        logic               flag;
        logic               last;
    } t_cell;

    typedef struct packed {
        logic [15:0]        cell_number;
        logic               updated;
        logic signed [31:0] d_mean;
        logic signed [31:0] d_slope;
        logic signed [31:0] m_mean;
        logic signed [31:0] m_slope;
        logic signed [31:0] e_mean;
        logic signed [31:0] e_slope;
        logic               row_done;
    } t_coeffs;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [31:0] i_left_node = '0;
    logic signed [31:0] i_right_node = '0;
    logic signed [31:0] i_density_value = '0;
    logic signed [31:0] i_momentum_value = '0;
    logic signed [31:0] i_energy_value = '0;
    logic i_reconstruct_flag = 1'b0;
    logic i_final_cell = 1'b0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [15:0] o_cell_number;
    logic o_updated;
    logic signed [31:0] o_density_mean, o_density_slope;
    logic signed [31:0] o_momentum_mean, o_momentum_slope;
    logic signed [31:0] o_energy_mean, o_energy_slope;
    logic o_row_done;

    slope_limited_linear_reconstruction u_dut (.*);

    always #5 i_clk = ~i_clk;

    t_cell   cells_pending[$];
    t_coeffs coeffs_expected[$];
    int      error_count = 0;
    longint  cycle_count = 0;
    bit      idle_enable = 1'b0;
    bit      stimulus_done = 1'b0;

    // window state
    longint win_vals[6];
    longint win_left[2];
    bit     win_flag;
    int     cell_index;
    int     win_fill;

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint qdiv(longint n, longint d);
        return d == 0 ? 0 : n / d;
    endfunction

    function automatic longint half_down(longint d);
        return d >= 0 ? d / 2 : -((-d + 1) / 2);
    endfunction

    function automatic t_coeffs constant_piece(int idx, longint cur[3], bit done);
        t_coeffs c;
        c = '0;
        c.cell_number = idx[15:0];
        c.updated = 1'b1;
        c.d_mean = cur[0][31:0];
        c.m_mean = cur[1][31:0];
        c.e_mean = cur[2][31:0];
        c.row_done = done;
        return c;
    endfunction

    function automatic t_coeffs interior_piece(int idx, longint cur[3], longint nl, longint nr);
        longint one, dxl, dxr, lim, r, cen;
        longint dl[3], dr[3], sl[3];
        t_coeffs c;
        one = longint'(1) << FRAC;
        c = '0;
        c.cell_number = idx[15:0];
        if (!win_flag) return c;
        dxl = half_down(nl - win_left[0]);
        dxr = half_down(nr - win_left[1]);
        for (int v = 0; v < 3; v++) begin
            dl[v] = sat(qdiv((win_vals[3+v] - win_vals[v]) * one, dxl), -2147483647, 2147483647);
            dr[v] = sat(qdiv((cur[v] - win_vals[3+v]) * one, dxr), -2147483647, 2147483647);
        end
        lim = 0;
        if (dl[1] != 0 && dr[1] != 0) begin
            r = qdiv(dl[1] * one, dr[1]);
            if (r <= 0) lim = 0;
            else if (r <= one) lim = r;
            else lim = qdiv(2 * one * one, one + r);
        end
        for (int v = 0; v < 3; v++) begin
            cen = sat(qdiv(dxr * dl[v] + dxl * dr[v], dxl + dxr), -64'sd2147483648,
                      2147483647);
            sl[v] = sat(lim * cen / one, -64'sd2147483648, 2147483647);
        end
        c.updated = 1'b1;
        c.d_mean = win_vals[3][31:0];
        c.m_mean = win_vals[4][31:0];
        c.e_mean = win_vals[5][31:0];
        c.d_slope = sl[0][31:0];
        c.m_slope = sl[1][31:0];
        c.e_slope = sl[2][31:0];
        return c;
    endfunction

    task automatic reconstruct_cell(t_cell t);
        longint cur[3];
        int mask;
        mask = (1 << IDX_BITS) - 1;
        cur[0] = t.density;
        cur[1] = t.momentum;
        cur[2] = t.energy;
        if (win_fill == 0) begin
            coeffs_expected.push_back(constant_piece(cell_index, cur, t.last));
        end else begin
            if (win_fill >= 2)
                coeffs_expected.push_back(interior_piece((cell_index - 1) & mask, cur,
                                                         t.left_node, t.right_node));
            if (t.last) coeffs_expected.push_back(constant_piece(cell_index, cur, 1'b1));
        end
        if (t.last) begin
            win_vals = '{default: 0};
            win_left = '{default: 0};
            win_flag = 1'b0;
            cell_index = 0;
            win_fill = 0;
        end else begin
            for (int v = 0; v < 3; v++) begin
                win_vals[v] = win_vals[3+v];
                win_vals[3+v] = cur[v];
            end
            win_left[0] = win_left[1];
            win_left[1] = t.left_node;
            win_flag = t.flag;
            cell_index = (cell_index + 1) & mask;
            if (win_fill < 2) win_fill++;
        end
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($urandom_range(0, 8)) - 32'd4;
            default: return $urandom();
        endcase
    endfunction

    // smooth-ish row content so the limiter sees all its branches
    function automatic t_cell row_cell(ref longint x, input bit last);
        t_cell t;
        longint w;
        w = $urandom_range(1, 4 * 65536);
        t.left_node = x[31:0];
        t.right_node = 32'(x + w);
        x = x + w;
        t.density = 32'(longint'($urandom_range(0, 1 << 20)) - (1 << 19));
        t.momentum = ($urandom_range(0, 9) == 0) ? 32'sd0 :
                     32'(longint'($urandom_range(0, 1 << 22)) - (1 << 21));
        t.energy = 32'($urandom());
        t.flag = $urandom_range(0, 4) != 0;
        t.last = last;
        return t;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || !o_stall) begin
                if (cells_pending.size() != 0 &&
                    !(idle_enable && $urandom_range(0, 99) < 29)) begin
                    t_cell t;
                    t = cells_pending.pop_front();
                    reconstruct_cell(t);
                    i_valid <= 1'b1;
                    i_left_node <= t.left_node;
                    i_right_node <= t.right_node;
                    i_density_value <= t.density;
                    i_momentum_value <= t.momentum;
                    i_energy_value <= t.energy;
                    i_reconstruct_flag <= t.flag;
                    i_final_cell <= t.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (coeffs_expected.size() == 0) begin
                    $error("unexpected result transfer, cell_number %0d", o_cell_number);
                    error_count++;
                end else begin
                    t_coeffs e;
                    e = coeffs_expected.pop_front();
                    if (o_cell_number !== e.cell_number) begin
                        $error("cell_number exp %0d got %0d", e.cell_number, o_cell_number);
                        error_count++;
                    end
                    if (o_updated !== e.updated) begin
                        $error("updated exp %0d got %0d", e.updated, o_updated);
                        error_count++;
                    end
                    if (o_density_mean !== e.d_mean) begin
                        $error("density_mean exp %0d got %0d", e.d_mean, o_density_mean);
                        error_count++;
                    end
                    if (o_density_slope !== e.d_slope) begin
                        $error("density_slope exp %0d got %0d", e.d_slope, o_density_slope);
                        error_count++;
                    end
                    if (o_momentum_mean !== e.m_mean) begin
                        $error("momentum_mean exp %0d got %0d", e.m_mean, o_momentum_mean);
                        error_count++;
                    end
                    if (o_momentum_slope !== e.m_slope) begin
                        $error("momentum_slope exp %0d got %0d", e.m_slope, o_momentum_slope);
                        error_count++;
                    end
                    if (o_energy_mean !== e.e_mean) begin
                        $error("energy_mean exp %0d got %0d", e.e_mean, o_energy_mean);
                        error_count++;
                    end
                    if (o_energy_slope !== e.e_slope) begin
                        $error("energy_slope exp %0d got %0d", e.e_slope, o_energy_slope);
                        error_count++;
                    end
                    if (o_row_done !== e.row_done) begin
                        $error("row_done exp %0d got %0d", e.row_done, o_row_done);
                        error_count++;
                    end
                end
            end
            i_stall <= idle_enable && ($urandom_range(0, 99) < 29);
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        t_cell t;
        longint x;
        int row_len;
        int n_total;
        win_vals = '{default: 0};
        win_left = '{default: 0};
        win_flag = 1'b0;
        cell_index = 0;
        win_fill = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single-cell row, extremes
        cells_pending.push_back('{32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                                  32'sh80000000, 32'sh7fffffff, 1'b1, 1'b1});
        // row: opposing momentum derivatives, then r above one, skipped cell, zero width
        cells_pending.push_back('{0, 65536, 0, 0, 32'sh80000000, 1, 0});
        cells_pending.push_back('{65536, 131072, 65536, 65536, 0, 1, 0});
        cells_pending.push_back('{131072, 196608, 0, 0, 32'sh7fffffff, 1, 0});
        cells_pending.push_back('{196608, 262144, 65536, 262144, 5, 1, 0});
        cells_pending.push_back('{262144, 327680, 70000, 300000, 9, 1, 0});
        cells_pending.push_back('{327680, 393216, 1, 300000, -9, 0, 0});
        cells_pending.push_back('{393216, 393216, 2, 5, 7, 1, 0});
        cells_pending.push_back('{393216, 393216, 32'sh7fffffff, 32'sh7fffffff,
                                  32'sh80000000, 1, 0});
        cells_pending.push_back('{32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                                  32'sh80000000, 32'sh7fffffff, 1, 0});
        cells_pending.push_back('{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                                  32'sh7fffffff, 32'sh80000000, 1, 0});
        cells_pending.push_back('{-5, -1, -3, 32'sh80000000, 1, 1, 1});
        // two-cell row
        cells_pending.push_back('{10, 20, 30, 40, 50, 1, 0});
        cells_pending.push_back('{20, 30, 31, 41, 51, 0, 1});

        // random rows, mostly well formed
        while (cells_pending.size() < 1450) begin
            if ($urandom_range(0, 7) == 0) begin
                t = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                     1'($urandom()), 1'($urandom_range(0, 3) == 0)};
                cells_pending.push_back(t);
            end else begin
                x = longint'($urandom_range(0, 1 << 20)) - (1 << 19);
                row_len = $urandom_range(1, 12);
                for (int k = 0; k < row_len; k++)
                    cells_pending.push_back(row_cell(x, k == row_len - 1));
            end
        end
        // one long row to wrap nothing but exercise a deep window
        x = 0;
        for (int k = 0; k < 40; k++) cells_pending.push_back(row_cell(x, k == 39));

        // first 300 cells offered without idle gaps, random idling and output stalls after that
        n_total = cells_pending.size();
        wait (cells_pending.size() + 300 <= n_total);
        idle_enable = 1'b1;

        wait (cells_pending.size() == 0);
        @(posedge i_clk);
        stimulus_done = 1'b1;
        wait (coeffs_expected.size() == 0);
        repeat (1000) @(posedge i_clk);
        if (error_count == 0 && coeffs_expected.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
rtl/slr_pkg.sv
rtl/slr_div.sv
rtl/slr_dpath.sv
rtl/slr_ctrl.sv
rtl/slope_limited_linear_reconstruction.sv
test/slope_limited_linear_reconstruction_test.sv
